// File: design/ssso_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the sorted set store.
// No dependencies.
package ssso_pkg;

    localparam int SET_DEPTH_DEF = 16;
    localparam int VAL_W         = 32;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_DELETE = 3'd1,
        OP_MEMBER = 3'd2,
        OP_UNION  = 3'd3,
        OP_INTER  = 3'd4,
        OP_DIFF   = 3'd5,
        OP_RSVD6  = 3'd6,
        OP_RSVD7  = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DUP       = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // One queued transaction between the front and back parts.
    typedef struct packed {
        t_op                op;
        logic               sel;
        logic [VAL_W-1:0]   value;
    } t_qent;

endpackage

// File: design/ssso_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ssso_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: design/ssso_front.sv
`timescale 1ns / 1ps
// Front part: accepts transactions, drops unused op codes, two-entry queue.
// Depends on ssso_pkg.
module ssso_front import ssso_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [2:0]        i_op,
    input  logic              i_which_set,
    input  logic [VAL_W-1:0]  i_value,
    output logic              o_q_valid,
    output t_qent             o_q_ent,
    input  logic              i_q_pop
);
    t_qent       r_q [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;
    logic        push;

    // op codes six and seven are taken but discarded
    assign push       = i_in_valid && !o_in_stall && (i_op <= OP_DIFF);
    assign o_in_stall = (r_cnt == 2'd2);
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_ent    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= '{op: t_op'(i_op), sel: i_which_set, value: i_value};
                r_wp      <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end
endmodule

// File: design/ssso_back.sv
`timescale 1ns / 1ps
// Back part: sequencer over the two set RAMs plus the result register.
// Depends on ssso_pkg and ssso_ram.
module ssso_back import ssso_pkg::*; #(
    parameter int SET_DEPTH = SET_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_qent             i_q_ent,
    output logic              o_q_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [VAL_W-1:0]  o_result_value,
    output logic              o_last,
    output logic              o_found,
    output logic [1:0]        o_status,
    output logic              o_empty_result
);
    localparam int AW = $clog2(SET_DEPTH);
    localparam int CW = $clog2(SET_DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(SET_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN, S_CHK, S_SH_RD, S_SH_WR, S_RESP,
        S_MG, S_MG_CMP, S_MG_TX, S_MG_TY, S_FIN
    } t_state;

    t_state            r_state, n_state;
    t_op               r_op, n_op;
    logic              r_sel, n_sel;
    logic [VAL_W-1:0]  r_v, n_v;
    logic [CW-1:0]     r_cnt_a, n_cnt_a, r_cnt_b, n_cnt_b;
    logic [CW-1:0]     r_i, n_i, r_j, n_j, r_pos, n_pos;
    logic              r_hit, n_hit;
    logic              r_hv, n_hv;
    logic [VAL_W-1:0]  r_held, n_held;
    t_status           r_rst_st, n_rst_st;
    logic              r_ov;
    logic [VAL_W-1:0]  r_o_val;
    logic              r_o_last, r_o_found, r_o_empty;
    t_status           r_o_st;

    logic              ld, ld_last, ld_found, ld_empty;
    logic [VAL_W-1:0]  ld_val;
    t_status           ld_st;
    logic              out_free;

    logic              we_a, we_b;
    logic [AW-1:0]     waddr, raddr_a, raddr_b, scan_addr;
    logic [VAL_W-1:0]  wdata, rd_a, rd_b;

    logic [CW-1:0]     cur_cnt, x_cnt, y_cnt, im1, ip1;
    logic [VAL_W-1:0]  rd_sel, xd, yd;
    logic              swap, mg_go;

    ssso_ram #(.WIDTH(VAL_W), .DEPTH(SET_DEPTH)) u_ram_a (
        .i_clk(i_clk), .i_we(we_a), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr_a), .o_rdata(rd_a)
    );
    ssso_ram #(.WIDTH(VAL_W), .DEPTH(SET_DEPTH)) u_ram_b (
        .i_clk(i_clk), .i_we(we_b), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr_b), .o_rdata(rd_b)
    );

    assign out_free = !r_ov || !i_out_stall;
    assign cur_cnt  = r_sel ? r_cnt_b : r_cnt_a;
    assign rd_sel   = r_sel ? rd_b : rd_a;
    // difference B minus A walks B as the outer list
    assign swap     = (r_op == OP_DIFF) && r_sel;
    assign x_cnt    = swap ? r_cnt_b : r_cnt_a;
    assign y_cnt    = swap ? r_cnt_a : r_cnt_b;
    assign xd       = swap ? rd_b : rd_a;
    assign yd       = swap ? rd_a : rd_b;
    assign im1      = r_i - 1'b1;
    assign ip1      = r_i + 1'b1;
    // holding a value with nowhere to put it freezes the merge
    assign mg_go    = !(r_hv && !out_free);

    always_comb begin
        n_state = r_state; n_op = r_op; n_sel = r_sel; n_v = r_v;
        n_cnt_a = r_cnt_a; n_cnt_b = r_cnt_b;
        n_i = r_i; n_j = r_j; n_pos = r_pos; n_hit = r_hit;
        n_hv = r_hv; n_held = r_held; n_rst_st = r_rst_st;
        o_q_pop = 1'b0;
        we_a = 1'b0; we_b = 1'b0; waddr = '0; wdata = r_v;
        scan_addr = r_i[AW-1:0];
        ld = 1'b0; ld_val = '0; ld_last = 1'b0; ld_found = 1'b0;
        ld_st = ST_OK; ld_empty = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_op = i_q_ent.op; n_sel = i_q_ent.sel; n_v = i_q_ent.value;
                    n_i = '0; n_j = '0; n_pos = '0; n_hit = 1'b0; n_hv = 1'b0;
                    n_state = (i_q_ent.op >= OP_UNION) ? S_MG : S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_i != cur_cnt) begin
                    n_state = S_CHK;
                end else begin
                    n_rst_st = ST_OK;
                    n_state  = S_RESP;
                    if (r_op == OP_INSERT) begin
                        if (r_hit) begin
                            n_rst_st = ST_DUP;
                        end else if (cur_cnt == FULL_CNT) begin
                            n_rst_st = ST_FULL;
                        end else begin
                            n_i = cur_cnt;
                            n_state = S_SH_RD;
                        end
                    end else if (r_op == OP_DELETE) begin
                        if (!r_hit) begin
                            n_rst_st = ST_NOT_FOUND;
                        end else begin
                            n_i = r_pos;
                            n_state = S_SH_RD;
                        end
                    end
                end
            end
            S_CHK: begin
                // insert: r_pos counts smaller entries; delete: index of match
                if (rd_sel == r_v) begin
                    n_hit = 1'b1;
                    if (r_op != OP_INSERT) n_pos = r_i;
                end
                if (r_op == OP_INSERT && $signed(rd_sel) < $signed(r_v)) begin
                    n_pos = r_pos + 1'b1;
                end
                n_i = ip1;
                n_state = S_SCAN;
            end
            S_SH_RD: begin
                if (r_op == OP_INSERT) begin
                    scan_addr = im1[AW-1:0];
                    if (r_i == r_pos) begin
                        waddr = r_pos[AW-1:0];
                        we_a = !r_sel; we_b = r_sel;
                        if (r_sel) n_cnt_b = r_cnt_b + 1'b1;
                        else       n_cnt_a = r_cnt_a + 1'b1;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_SH_WR;
                    end
                end else begin
                    scan_addr = ip1[AW-1:0];
                    if (ip1 >= cur_cnt) begin
                        if (r_sel) n_cnt_b = r_cnt_b - 1'b1;
                        else       n_cnt_a = r_cnt_a - 1'b1;
                        n_state = S_RESP;
                    end else begin
                        n_state = S_SH_WR;
                    end
                end
            end
            S_SH_WR: begin
                waddr = r_i[AW-1:0];
                wdata = rd_sel;
                we_a = !r_sel; we_b = r_sel;
                n_i = (r_op == OP_INSERT) ? im1 : ip1;
                n_state = S_SH_RD;
            end
            S_RESP: begin
                if (out_free) begin
                    ld = 1'b1; ld_last = 1'b1; ld_st = r_rst_st;
                    ld_found = (r_op == OP_MEMBER) && r_hit;
                    n_state = S_IDLE;
                end
            end
            S_MG: begin
                if (r_i < x_cnt && r_j < y_cnt)          n_state = S_MG_CMP;
                else if (r_op != OP_INTER && r_i < x_cnt) n_state = S_MG_TX;
                else if (r_op == OP_UNION && r_j < y_cnt) n_state = S_MG_TY;
                else                                      n_state = S_FIN;
            end
            S_MG_CMP: begin
                if (mg_go) begin
                    n_state = S_MG;
                    if ($signed(xd) < $signed(yd)) begin
                        n_i = ip1;
                        if (r_op != OP_INTER) begin
                            n_hv = 1'b1; n_held = xd; ld = r_hv;
                        end
                    end else if ($signed(yd) < $signed(xd)) begin
                        n_j = r_j + 1'b1;
                        if (r_op == OP_UNION) begin
                            n_hv = 1'b1; n_held = yd; ld = r_hv;
                        end
                    end else begin
                        n_i = ip1; n_j = r_j + 1'b1;
                        if (r_op != OP_DIFF) begin
                            n_hv = 1'b1; n_held = xd; ld = r_hv;
                        end
                    end
                    ld_val = r_held;
                end
            end
            S_MG_TX: begin
                if (mg_go) begin
                    n_i = ip1; n_hv = 1'b1; n_held = xd;
                    ld = r_hv; ld_val = r_held;
                    n_state = S_MG;
                end
            end
            S_MG_TY: begin
                if (mg_go) begin
                    n_j = r_j + 1'b1; n_hv = 1'b1; n_held = yd;
                    ld = r_hv; ld_val = r_held;
                    n_state = S_MG;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    ld = 1'b1; ld_last = 1'b1;
                    ld_val = r_hv ? r_held : '0;
                    ld_empty = !r_hv;
                    n_hv = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // merge reads both RAMs at (i, j); scans and shifts read one set
    always_comb begin
        if (r_state == S_MG || r_state == S_MG_CMP || r_state == S_MG_TX ||
            r_state == S_MG_TY || r_state == S_FIN) begin
            raddr_a = swap ? r_j[AW-1:0] : r_i[AW-1:0];
            raddr_b = swap ? r_i[AW-1:0] : r_j[AW-1:0];
        end else begin
            raddr_a = scan_addr;
            raddr_b = scan_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_hv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt_a <= n_cnt_a;
            r_cnt_b <= n_cnt_b;
            r_hv    <= n_hv;
            if (ld)               r_ov <= 1'b1;
            else if (!i_out_stall) r_ov <= 1'b0;
        end
        r_op <= n_op; r_sel <= n_sel; r_v <= n_v;
        r_i <= n_i; r_j <= n_j; r_pos <= n_pos; r_hit <= n_hit;
        r_held <= n_held; r_rst_st <= n_rst_st;
        if (ld) begin
            r_o_val <= ld_val; r_o_last <= ld_last; r_o_found <= ld_found;
            r_o_st <= ld_st; r_o_empty <= ld_empty;
        end
    end

    assign o_out_valid    = r_ov;
    assign o_result_value = r_o_val;
    assign o_last         = r_o_last;
    assign o_found        = r_o_found;
    assign o_status       = r_o_st;
    assign o_empty_result = r_o_empty;
endmodule

// File: design/sorted_set_store_with_set_ops_core.sv
`timescale 1ns / 1ps
// Two sorted sets (A, B) with insert/delete/member and union/intersection/difference.
// Member scans the chosen set entry by entry; insert/delete then shift each moved entry in turn.
// Set ops: each merge step first addresses both RAMs (S_MG), then acts on the registered read data.
// A two-entry queue decouples intake from the sequencer; results leave via one register.
// Reset (sync, active low) clears both counts, the state and the valid flags; set RAMs are not cleared.
// Depends on ssso_pkg, ssso_front, ssso_back, ssso_ram.
module sorted_set_store_with_set_ops_core import ssso_pkg::*; #(
    parameter int SET_DEPTH = SET_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [2:0]               i_op,
    input  logic                     i_which_set,
    input  logic signed [VAL_W-1:0]  i_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [VAL_W-1:0]  o_result_value,
    output logic                     o_last,
    output logic                     o_found,
    output logic [1:0]               o_status,
    output logic                     o_empty_result
);
    // queue handshake between intake and sequencer
    logic   q_valid, q_pop;
    t_qent  q_ent;

    // Front: takes every transaction while the queue has room; op codes
    // six and seven are accepted and dropped without a result.
    ssso_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_op(i_op), .i_which_set(i_which_set), .i_value(i_value),
        .o_q_valid(q_valid), .o_q_ent(q_ent), .i_q_pop(q_pop)
    );

    // Back: scans/shifts for single-set ops, two-pointer merge for set ops.
    // The last merge value is held back so it can be tagged as last.
    ssso_back #(.SET_DEPTH(SET_DEPTH)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .i_q_ent(q_ent), .o_q_pop(q_pop),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_result_value(o_result_value), .o_last(o_last), .o_found(o_found),
        .o_status(o_status), .o_empty_result(o_empty_result)
    );
endmodule

// File: tb/tb_sorted_set_store_with_set_ops_core.sv
`timescale 1ns / 1ps
// Testbench for sorted_set_store_with_set_ops_core: random and directed set traffic
// checked against a behavioral model of the two sorted sets. Depends on ssso_pkg.
module tb_sorted_set_store_with_set_ops_core;
    import ssso_pkg::*;

    localparam int DEPTH = SET_DEPTH_DEF;
    localparam int STALL_HOLD = 400;      // long receiver hold-off, in cycles
    localparam int WATCHDOG = 20000;      // cycles with no accepted transaction

    // One input transaction as the driver offers it.
    typedef struct packed {
        t_op                op;
        logic               sel;
        logic [VAL_W-1:0]   value;
    } t_cmd;

    // One result transaction as the block returns it.
    typedef struct packed {
        logic [VAL_W-1:0]   value;
        logic               last;
        logic               found;
        t_status            status;
        logic               empty;
    } t_res;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [2:0] i_op = '0;
    logic i_which_set = 1'b0;
    logic signed [VAL_W-1:0] i_value = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic signed [VAL_W-1:0] o_result_value;
    logic o_last, o_found, o_empty_result;
    logic [1:0] o_status;

    sorted_set_store_with_set_ops_core dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Model state: both sets kept as ascending signed lists.
    logic signed [VAL_W-1:0] set_a[$];
    logic signed [VAL_W-1:0] set_b[$];
    t_res  pending_results[$];
    t_cmd  cmd_queue[$];

    int  mismatches = 0;
    int  idle_pct = 0;      // sender idle percentage for the current phase
    int  stall_pct = 0;     // receiver stall percentage for the current phase
    bit  hold_rx = 1'b0;    // request for a long receiver hold-off
    bit  sender_pause = 1'b0;
    int  quiet_cycles = 0;

    function automatic t_res single_answer(logic fnd, t_status st);
        t_res r;
        r = '{value: '0, last: 1'b1, found: fnd, status: st, empty: 1'b0};
        return r;
    endfunction

    function automatic t_res merged_value(logic signed [VAL_W-1:0] v);
        t_res r;
        r = '{value: v, last: 1'b0, found: 1'b0, status: ST_OK, empty: 1'b0};
        return r;
    endfunction

    // Merge two sorted lists; mode picks union, intersection or x minus y.
    task automatic merge_sets(ref logic signed [VAL_W-1:0] x[$],
                              ref logic signed [VAL_W-1:0] y[$], input t_op mode);
        int i, j, n;
        t_res r;
        i = 0; j = 0; n = 0;
        while (i < x.size() && j < y.size()) begin
            if (x[i] < y[j]) begin
                if (mode != OP_INTER) begin pending_results.push_back(merged_value(x[i])); n++; end
                i++;
            end else if (y[j] < x[i]) begin
                if (mode == OP_UNION) begin pending_results.push_back(merged_value(y[j])); n++; end
                j++;
            end else begin
                if (mode != OP_DIFF) begin pending_results.push_back(merged_value(x[i])); n++; end
                i++; j++;
            end
        end
        if (mode != OP_INTER)
            for (; i < x.size(); i++) begin pending_results.push_back(merged_value(x[i])); n++; end
        if (mode == OP_UNION)
            for (; j < y.size(); j++) begin pending_results.push_back(merged_value(y[j])); n++; end
        if (n == 0) begin
            r = '{value: '0, last: 1'b1, found: 1'b0, status: ST_OK, empty: 1'b1};
            pending_results.push_back(r);
        end else begin
            pending_results[$].last = 1'b1;
        end
    endtask

    // Insert, delete and member on one chosen set.
    task automatic update_set(ref logic signed [VAL_W-1:0] s[$], input t_cmd c);
        int pos;
        bit hit;
        hit = 1'b0;
        pos = 0;
        foreach (s[k]) if (s[k] == $signed(c.value)) begin hit = 1'b1; pos = k; end
        case (c.op)
            OP_INSERT: begin
                if (hit) pending_results.push_back(single_answer(1'b0, ST_DUP));
                else if (s.size() >= DEPTH) pending_results.push_back(single_answer(1'b0, ST_FULL));
                else begin
                    pos = 0;
                    while (pos < s.size() && s[pos] < $signed(c.value)) pos++;
                    s.insert(pos, $signed(c.value));
                    pending_results.push_back(single_answer(1'b0, ST_OK));
                end
            end
            OP_DELETE: begin
                if (!hit) pending_results.push_back(single_answer(1'b0, ST_NOT_FOUND));
                else begin
                    s.delete(pos);
                    pending_results.push_back(single_answer(1'b0, ST_OK));
                end
            end
            default: pending_results.push_back(single_answer(hit, ST_OK));
        endcase
    endtask

    task automatic predict_results(t_cmd c);
        case (c.op)
            OP_INSERT, OP_DELETE, OP_MEMBER: begin
                if (c.sel) update_set(set_b, c);
                else update_set(set_a, c);
            end
            OP_UNION: merge_sets(set_a, set_b, OP_UNION);
            OP_INTER: merge_sets(set_a, set_b, OP_INTER);
            OP_DIFF: begin
                if (c.sel) merge_sets(set_b, set_a, OP_DIFF);
                else merge_sets(set_a, set_b, OP_DIFF);
            end
            default: ;  // reserved codes produce nothing
        endcase
    endtask

    // Driver: offers the next queued command; payload holds while stalled.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                predict_results(t_cmd'({t_op'(i_op), i_which_set, i_value}));
                if (cmd_queue.size() > 0 && !sender_pause && $urandom_range(99) >= idle_pct) begin
                    t_cmd c;
                    c = cmd_queue.pop_front();
                    i_op <= c.op; i_which_set <= c.sel; i_value <= c.value;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end else if (!i_in_valid && cmd_queue.size() > 0 && !sender_pause
                         && $urandom_range(99) >= idle_pct) begin
                t_cmd c;
                c = cmd_queue.pop_front();
                i_op <= c.op; i_which_set <= c.sel; i_value <= c.value;
                i_in_valid <= 1'b1;
            end
        end
    end

    // Receiver stall: random per phase, or a long counted hold-off on request.
    int hold_count = 0;
    always @(posedge i_clk) begin
        if (hold_rx && hold_count == 0) hold_count <= STALL_HOLD;
        else if (hold_count > 0) hold_count <= hold_count - 1;
        if (hold_count > 1 || (hold_rx && hold_count == 0))
            i_out_stall <= 1'b1;
        else
            i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Monitor: each accepted result against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (o_out_valid && !i_out_stall) begin
                t_res got, want;
                got = '{value: o_result_value, last: o_last, found: o_found,
                        status: t_status'(o_status), empty: o_empty_result};
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: value=%0d last=%b found=%b status=%0d empty=%b",
                                 $signed(got.value), got.last, got.found, got.status, got.empty);
                end else begin
                    want = pending_results.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: exp value=%0d last=%b found=%b status=%0d empty=%b / got value=%0d last=%b found=%b status=%0d empty=%b",
                                     $signed(want.value), want.last, want.found, want.status, want.empty,
                                     $signed(got.value), got.last, got.found, got.status, got.empty);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge i_clk) begin
        if (quiet_cycles >= WATCHDOG) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return $urandom;
            default: return VAL_W'($signed($urandom_range(40)) - 20);  // small pool for hits
        endcase
    endfunction

    task automatic add(t_op op, logic sel, logic [VAL_W-1:0] v);
        cmd_queue.push_back('{op: op, sel: sel, value: v});
    endtask

    task automatic wait_drained();
        while (cmd_queue.size() > 0 || i_in_valid) @(posedge i_clk);
        while (pending_results.size() > 0) @(posedge i_clk);
    endtask

    // Mostly well-formed traffic: inserts to fill, lookups, merges, some junk ops.
    task automatic random_batch(int n);
        int r;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 35) add(OP_INSERT, $urandom_range(1), pick_value());
            else if (r < 55) add(OP_DELETE, $urandom_range(1), pick_value());
            else if (r < 70) add(OP_MEMBER, $urandom_range(1), pick_value());
            else if (r < 78) add(OP_UNION, $urandom_range(1), $urandom);
            else if (r < 86) add(OP_INTER, $urandom_range(1), $urandom);
            else if (r < 96) add(OP_DIFF, $urandom_range(1), $urandom);
            else add($urandom_range(1) ? OP_RSVD6 : OP_RSVD7, $urandom_range(1), $urandom);
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty results, extremes, duplicates, absent deletes, full set.
        add(OP_UNION, 1'b0, '0);
        add(OP_INTER, 1'b0, '0);
        add(OP_DIFF, 1'b1, '0);
        add(OP_INSERT, 1'b0, 32'h8000_0000);
        add(OP_INSERT, 1'b0, 32'h7FFF_FFFF);
        add(OP_INSERT, 1'b0, 32'h7FFF_FFFF);
        add(OP_INSERT, 1'b1, 32'h0000_0000);
        add(OP_INSERT, 1'b1, 32'h7FFF_FFFF);
        add(OP_MEMBER, 1'b0, 32'h8000_0000);
        add(OP_MEMBER, 1'b1, 32'hFFFF_FFFF);
        add(OP_DELETE, 1'b1, 32'h1234_5678);
        add(OP_UNION, 1'b0, 32'hFFFF_FFFF);
        add(OP_INTER, 1'b1, '0);
        add(OP_DIFF, 1'b0, '0);
        add(OP_DIFF, 1'b1, '0);
        add(OP_RSVD6, 1'b1, 32'hFFFF_FFFF);
        add(OP_RSVD7, 1'b0, '0);
        for (int k = 0; k < DEPTH; k++) add(OP_INSERT, 1'b1, VAL_W'(k * 3 - 20));
        add(OP_INSERT, 1'b1, 32'h0000_0001);        // full, still a duplicate check first
        add(OP_UNION, 1'b0, '0);
        add(OP_DELETE, 1'b0, 32'h8000_0000);
        wait_drained();

        idle_pct = 0;  stall_pct = 0;  random_batch(80);  wait_drained();
        idle_pct = 55; stall_pct = 0;  random_batch(70);  wait_drained();
        idle_pct = 0;  stall_pct = 55; random_batch(70);  wait_drained();

        // Long receiver hold-off while the sender keeps offering.
        idle_pct = 0; stall_pct = 0;
        hold_rx = 1'b1;
        random_batch(20);
        // keep the request up until the stall process has taken it
        while (hold_count == 0) @(posedge i_clk);
        hold_rx = 1'b0;
        wait_drained();

        // Sender pause until every result is back.
        idle_pct = 24; stall_pct = 24; random_batch(40);
        sender_pause = 1'b1;
        while (pending_results.size() > 0 || i_in_valid) @(posedge i_clk);
        sender_pause = 1'b0;
        random_batch(40);
        wait_drained();

        repeat (200) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
